>>> rtl/lattice_neighbour_generator_defines.svh
// Assertion macros for the lattice neighbour generator.
`ifndef LATTICE_NEIGHBOUR_GENERATOR_DEFINES_SVH
`define LATTICE_NEIGHBOUR_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LNG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define LNG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lng_pkg.sv
// Shared constants and types of the lattice neighbour generator.
`default_nettype none

package lng_pkg;

  localparam int IDX_W     = 12;
  localparam int SIDE_W    = 13;
  localparam int DIMS_W    = 2;
  localparam int MAX_SITES = 4096;
  // largest sides whose square and cube still fit in MAX_SITES
  localparam int SQ_LIMIT  = 64;
  localparam int CU_LIMIT  = 16;
  localparam int SQ_W      = $clog2(SQ_LIMIT + 1);
  localparam int CU_W      = $clog2(CU_LIMIT + 1);

  localparam int NB_SLOTS     = 6;
  localparam int DIV1_BITS    = IDX_W;
  localparam int DIV2_BITS    = 8;
  localparam int FRONT_STAGES = DIV1_BITS + DIV2_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_DIMS     = 2'd0;
  localparam logic [1:0] REG_SIDE     = 2'd1;
  localparam logic [1:0] REG_PERIODIC = 2'd2;

  localparam logic [DIMS_W-1:0] DIM_CHAIN  = 2'd1;
  localparam logic [DIMS_W-1:0] DIM_SQUARE = 2'd2;
  localparam logic [DIMS_W-1:0] DIM_CUBE   = 2'd3;

  typedef struct packed {
    logic [DIMS_W-1:0] dims;
    logic [SIDE_W-1:0] side;
    logic              periodic;
    logic [SIDE_W-1:0] side_sq;
    logic [SIDE_W-1:0] side_cu;
    logic [IDX_W-1:0]  col_wrap;
    logic [IDX_W-1:0]  row_wrap;
    logic [IDX_W-1:0]  plane_wrap;
  } cfg_t;

  typedef struct packed {
    logic [NB_SLOTS-1:0]            mask;
    logic [NB_SLOTS-1:0][IDX_W-1:0] nb;
    logic                           none;
    logic                           err;
  } desc_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/lng_if.sv
// Site and result channel interfaces.
`default_nettype none

interface lng_site_if;
  import lng_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] site_index;
  modport source (output valid, output site_index, input ready);
  modport sink (input valid, input site_index, output ready);
endinterface

interface lng_nb_if;
  import lng_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] neighbour_index;
  logic             is_last;
  logic             no_neighbour;
  logic             out_of_range;
  modport source (output valid, output neighbour_index, output is_last,
                  output no_neighbour, output out_of_range, input ready);
  modport sink (input valid, input neighbour_index, input is_last,
                input no_neighbour, input out_of_range, output ready);
endinterface

`default_nettype wire

>>> rtl/lng_cfg.sv
// APB configuration registers and derived lattice sizes.
`default_nettype none

module lng_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lng_pkg::PADDR_W-1:0] paddr,
  input  logic [lng_pkg::PDATA_W-1:0] pwdata,
  output logic [lng_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output lng_pkg::cfg_t               cfg
);
  import lng_pkg::*;

  logic [DIMS_W-1:0] dims;
  logic [SIDE_W-1:0] side;
  logic              periodic;
  logic [SIDE_W-1:0] side_sq;
  logic [SIDE_W-1:0] side_cu;
  logic [IDX_W-1:0]  col_wrap;
  logic [IDX_W-1:0]  row_wrap;
  logic [IDX_W-1:0]  plane_wrap;

  logic              wr;
  logic [1:0]        reg_sel;
  logic [SIDE_W-1:0] wside;
  logic [2*SQ_W-1:0] sq_prod;

  function automatic logic [SIDE_W-1:0] cube_of(input logic [CU_W-1:0] v);
    logic [SIDE_W-1:0] c;
    unique case (v)
      5'd0:    c = 13'd0;
      5'd1:    c = 13'd1;
      5'd2:    c = 13'd8;
      5'd3:    c = 13'd27;
      5'd4:    c = 13'd64;
      5'd5:    c = 13'd125;
      5'd6:    c = 13'd216;
      5'd7:    c = 13'd343;
      5'd8:    c = 13'd512;
      5'd9:    c = 13'd729;
      5'd10:   c = 13'd1000;
      5'd11:   c = 13'd1331;
      5'd12:   c = 13'd1728;
      5'd13:   c = 13'd2197;
      5'd14:   c = 13'd2744;
      5'd15:   c = 13'd3375;
      5'd16:   c = 13'd4096;
      default: c = '0;
    endcase
    return c;
  endfunction

  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign wside   = pwdata[SIDE_W-1:0];
  assign sq_prod = wside[SQ_W-1:0] * wside[SQ_W-1:0];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims     <= DIM_CHAIN;
      side     <= SIDE_W'(1);
      periodic <= 1'b1;
      side_sq  <= SIDE_W'(1);
      side_cu  <= SIDE_W'(1);
    end else if (wr) begin
      unique case (reg_sel)
        REG_DIMS: begin
          dims <= pwdata[DIMS_W-1:0];
        end
        REG_SIDE: begin
          side    <= wside;
          side_sq <= (wside <= SIDE_W'(SQ_LIMIT)) ? sq_prod[SIDE_W-1:0] : '0;
          side_cu <= (wside <= SIDE_W'(CU_LIMIT)) ? cube_of(wside[CU_W-1:0]) : '0;
        end
        REG_PERIODIC: begin
          periodic <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // wrap offsets (s-1)*stride, used only at the end of the divider pipeline
  always_ff @(posedge clk) begin
    col_wrap   <= side[IDX_W-1:0] - IDX_W'(1);
    row_wrap   <= side_sq[IDX_W-1:0] - side[IDX_W-1:0];
    plane_wrap <= side_cu[IDX_W-1:0] - side_sq[IDX_W-1:0];
  end

  always_comb begin
    unique case (reg_sel)
      REG_DIMS:     prdata = PDATA_W'(dims);
      REG_SIDE:     prdata = PDATA_W'(side);
      REG_PERIODIC: prdata = PDATA_W'(periodic);
      default:      prdata = '0;
    endcase
  end

  assign cfg.dims       = dims;
  assign cfg.side       = side;
  assign cfg.periodic   = periodic;
  assign cfg.side_sq    = side_sq;
  assign cfg.side_cu    = side_cu;
  assign cfg.col_wrap   = col_wrap;
  assign cfg.row_wrap   = row_wrap;
  assign cfg.plane_wrap = plane_wrap;

endmodule

`default_nettype wire

>>> rtl/lng_front.sv
// Front end: coordinate divider pipeline and neighbour classification.
`default_nettype none

module lng_front (
  input  logic            clk,
  input  logic            rst,
  input  lng_pkg::cfg_t   cfg,
  lng_site_if.sink        site,
  input  logic            q_full,
  output logic            push,
  output lng_pkg::desc_t  push_desc
);
  import lng_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     q1;
    logic [SIDE_W-1:0]    r1;
    logic [DIV2_BITS-1:0] q2;
    logic [SIDE_W-1:0]    r2;
  } stage_t;

  typedef struct packed {
    logic             lo_ok;
    logic             hi_ok;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } axis_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [SIDE_W:0] div_step(input logic [SIDE_W-1:0] rem,
                                               input logic b,
                                               input logic [SIDE_W-1:0] d);
    logic [SIDE_W:0] t;
    logic [SIDE_W:0] diff;
    t    = {rem, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[SIDE_W-1:0]};
    end
    return {1'b0, t[SIDE_W-1:0]};
  endfunction

  function automatic axis_t axis_f(input logic [IDX_W-1:0] idx,
                                   input logic [SIDE_W-1:0] c,
                                   input logic [IDX_W-1:0] st,
                                   input logic [IDX_W-1:0] wrapoff,
                                   input logic [SIDE_W-1:0] s,
                                   input logic wrap);
    axis_t           a;
    logic            at_lo;
    logic            at_hi;
    logic [SIDE_W:0] c_inc;
    c_inc   = {1'b0, c} + (SIDE_W + 1)'(1);
    at_lo   = (c == '0);
    at_hi   = (c_inc >= {1'b0, s});
    a.lo_ok = !at_lo || wrap;
    a.lo    = at_lo ? idx + wrapoff : idx - st;
    a.hi_ok = !at_hi || wrap;
    a.hi    = at_hi ? idx - wrapoff : idx + st;
    return a;
  endfunction

  logic [FRONT_STAGES:0] vld;
  stage_t                stg [FRONT_STAGES+1];
  logic                  adv;

  assign adv        = !vld[FRONT_STAGES] || !q_full;
  assign site.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[FRONT_STAGES-1:0], site.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].idx <= site.site_index;
      stg[0].q1  <= '0;
      stg[0].r1  <= '0;
      stg[0].q2  <= '0;
      stg[0].r2  <= '0;
    end
  end

  // idx / side in the first stages, then (idx / side) / side for the cube
  for (genvar k = 0; k < FRONT_STAGES; k++) begin : g_stage
    stage_t nxt;
    if (k < DIV1_BITS) begin : g_div1
      localparam int B = DIV1_BITS - 1 - k;
      logic [SIDE_W:0] step;
      always_comb begin
        step       = div_step(stg[k].r1, stg[k].idx[B], cfg.side);
        nxt        = stg[k];
        nxt.q1[B]  = step[SIDE_W];
        nxt.r1     = step[SIDE_W-1:0];
      end
    end else begin : g_div2
      localparam int B = DIV2_BITS - 1 - (k - DIV1_BITS);
      logic [SIDE_W:0] step;
      always_comb begin
        step       = div_step(stg[k].r2, stg[k].q1[B], cfg.side);
        nxt        = stg[k];
        nxt.q2[B]  = step[SIDE_W];
        nxt.r2     = step[SIDE_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        stg[k+1] <= nxt;
      end
    end
  end

  stage_t            p;
  logic              over;
  logic              err;
  logic [SIDE_W-1:0] total;
  logic [SIDE_W-1:0] row_c;
  logic [SIDE_W-1:0] s_m1;
  axis_t             ax0;
  axis_t             ax1;
  axis_t             ax2;
  desc_t             d;

  assign p = stg[FRONT_STAGES];

  always_comb begin
    unique case (cfg.dims)
      DIM_CHAIN: begin
        over  = cfg.side > SIDE_W'(MAX_SITES);
        total = cfg.side;
      end
      DIM_SQUARE: begin
        over  = cfg.side > SIDE_W'(SQ_LIMIT);
        total = cfg.side_sq;
      end
      DIM_CUBE: begin
        over  = cfg.side > SIDE_W'(CU_LIMIT);
        total = cfg.side_cu;
      end
      default: begin
        over  = 1'b1;
        total = '0;
      end
    endcase
    err   = over || ({1'b0, p.idx} >= total);
    s_m1  = cfg.side - SIDE_W'(1);
    row_c = (cfg.dims == DIM_CUBE) ? p.r2 : {1'b0, p.q1};
    ax0   = axis_f(p.idx, p.r1, IDX_W'(1), cfg.col_wrap, cfg.side, cfg.periodic);
    ax1   = axis_f(p.idx, row_c, cfg.side[IDX_W-1:0], cfg.row_wrap, cfg.side,
                   cfg.periodic);
    ax2   = axis_f(p.idx, SIDE_W'(p.q2), cfg.side_sq[IDX_W-1:0], cfg.plane_wrap,
                   cfg.side, cfg.periodic);

    d = '0;
    if (cfg.dims == DIM_CHAIN) begin
      d.mask[0] = (p.idx != '0);
      d.nb[0]   = p.idx - IDX_W'(1);
      d.mask[1] = ({1'b0, p.idx} + SIDE_W'(1)) < cfg.side;
      d.nb[1]   = p.idx + IDX_W'(1);
      d.mask[2] = cfg.periodic && (p.idx == '0);
      d.nb[2]   = cfg.col_wrap;
      d.mask[3] = cfg.periodic && ({1'b0, p.idx} == s_m1);
      d.nb[3]   = '0;
    end else begin
      d.mask[0] = ax0.lo_ok;
      d.nb[0]   = ax0.lo;
      d.mask[1] = ax0.hi_ok;
      d.nb[1]   = ax0.hi;
      d.mask[2] = ax1.lo_ok;
      d.nb[2]   = ax1.lo;
      d.mask[3] = ax1.hi_ok;
      d.nb[3]   = ax1.hi;
      d.mask[4] = ax2.lo_ok && (cfg.dims == DIM_CUBE);
      d.nb[4]   = ax2.lo;
      d.mask[5] = ax2.hi_ok && (cfg.dims == DIM_CUBE);
      d.nb[5]   = ax2.hi;
    end
    d.err  = err;
    d.none = !err && (d.mask == '0);
    // flagged sites give a single zero result
    if (d.err || d.none) begin
      d.mask  = NB_SLOTS'(1);
      d.nb[0] = '0;
    end
  end

  assign push      = vld[FRONT_STAGES] && !q_full;
  assign push_desc = d;

endmodule

`default_nettype wire

>>> rtl/lng_queue.sv
// Descriptor queue between front and back.
`default_nettype none

module lng_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lng_pkg::desc_t    push_desc,
  input  logic              pop,
  output lng_pkg::desc_t    head,
  output lng_pkg::q_stat_t  stat
);
  import lng_pkg::*;

  desc_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

`default_nettype wire

>>> rtl/lng_back.sv
// Back end: walks a descriptor's slots and emits one result per cycle while the result channel is ready.
`default_nettype none

module lng_back (
  input  logic            clk,
  input  logic            rst,
  input  lng_pkg::desc_t  head,
  input  logic            head_vld,
  output logic            pop,
  lng_nb_if.source        result
);
  import lng_pkg::*;

  logic [NB_SLOTS-1:0] done;
  logic [NB_SLOTS-1:0] remaining;
  logic [NB_SLOTS-1:0] pick;
  logic                last;
  logic                load;
  logic [IDX_W-1:0]    sel_nb;

  logic                res_valid;
  logic [IDX_W-1:0]    res_index;
  logic                res_last;
  logic                res_none;
  logic                res_err;

  assign remaining = head.mask & ~done;
  assign pick      = remaining & (~remaining + NB_SLOTS'(1));
  assign last      = (remaining & ~pick) == '0;
  assign load      = head_vld && (!res_valid || result.ready);
  assign pop       = load && last;

  always_comb begin
    sel_nb = '0;
    for (int i = 0; i < NB_SLOTS; i++) begin
      if (pick[i]) begin
        sel_nb = sel_nb | head.nb[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        done      <= last ? '0 : (done | pick);
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_index <= sel_nb;
      res_last  <= last;
      res_none  <= head.none;
      res_err   <= head.err;
    end
  end

  assign result.valid           = res_valid;
  assign result.neighbour_index = res_index;
  assign result.is_last         = res_last;
  assign result.no_neighbour    = res_none;
  assign result.out_of_range    = res_err;

endmodule

`default_nettype wire

>>> rtl/lattice_neighbour_generator.sv
// Top level of the lattice neighbour generator.
//
// Channel  Dir  Handshake              Payload
// site     in   valid / ready          site_index[11:0]
// result   out  valid / ready          neighbour_index[11:0], is_last, no_neighbour,
//                                      out_of_range
// apb      in   psel/penable/pwrite    paddr[3:0], pwdata[31:0], prdata[31:0]
//
// A site is taken every cycle while the 4-entry queue has room; results leave one per
// cycle while the result channel is ready, and a site gives 1 to 6 results, one per
// neighbour or a single flagged one. Its first result comes after an input register,
// 20 divider stages at one quotient bit each, the queue write and the output register.
// rst clears all valids and the queue and restores dimensions 1, side 1, periodic 1.
// A stalled result channel fills the queue, then the divider pipeline stops as a whole.
`default_nettype none
`include "lattice_neighbour_generator_defines.svh"

module lattice_neighbour_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lng_pkg::PADDR_W-1:0] paddr,
  input  logic [lng_pkg::PDATA_W-1:0] pwdata,
  output logic [lng_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  lng_site_if.sink                    site,
  lng_nb_if.source                    result
);
  import lng_pkg::*;

  cfg_t    cfg;
  logic    q_push;
  desc_t   q_in;
  logic    q_pop;
  desc_t   q_head;
  q_stat_t q_stat;

  lng_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lng_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .site      (site),
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_desc (q_in)
  );

  lng_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  lng_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .head_vld (!q_stat.empty),
    .pop      (q_pop),
    .result   (result)
  );

  `LNG_ASSERT_IMP(a_err_alone, clk, rst, result.valid && result.out_of_range, result.is_last && !result.no_neighbour && (result.neighbour_index == '0), "out-of-range result is not a lone zero item")
  `LNG_ASSERT_IMP(a_none_alone, clk, rst, result.valid && result.no_neighbour, result.is_last && !result.out_of_range && (result.neighbour_index == '0), "no-neighbour result is not a lone zero item")
  `LNG_ASSERT_IMP(a_stall_cause, clk, rst, !site.ready, q_stat.full, "front stalled while the queue has room")
  `LNG_ASSERT_NXT(a_pop_last, clk, rst, q_pop, result.valid && result.is_last, "queue popped without a last result")

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the lattice neighbour generator.
`timescale 1ns / 1ps

module testbench;
  import lng_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG     = 3000;

  typedef struct packed {
    logic [IDX_W-1:0] nb;
    logic             last;
    logic             none;
    logic             oor;
  } nb_res_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lng_site_if site_ch ();
  lng_nb_if   nb_ch ();

  lattice_neighbour_generator u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .site    (site_ch),
    .result  (nb_ch)
  );

  // lattice setup as last written
  logic [DIMS_W-1:0] lat_dims     = DIM_CHAIN;
  logic [SIDE_W-1:0] lat_side     = 1;
  logic              lat_periodic = 1'b1;

  logic [IDX_W-1:0] site_queue[$];
  nb_res_t          nbr_expect[$];
  nb_res_t          want;
  int               errors = 0;
  int               send_gap;
  int               stall_left;
  int               recv_gap;
  int               quiet_cycles;
  bit               idle_on = 1'b0;
  logic             hold_armed = 1'b0;
  logic             hold_done;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int idle_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint unsigned lattice_sites();
    longint unsigned total;
    total = 1;
    for (int k = 0; k < lat_dims; k++) total *= lat_side;
    return total;
  endfunction

  function automatic void queue_site(input logic [IDX_W-1:0] s);
    site_queue = {site_queue, s};
  endfunction

  function automatic void expect_item(input nb_res_t r);
    nbr_expect = {nbr_expect, r};
  endfunction

  function automatic void add_nb(input longint unsigned v);
    expect_item(nb_res_t'{v[IDX_W-1:0], 1'b0, 1'b0, 1'b0});
  endfunction

  // neighbours in output order: left/right, top/bottom, front/back
  function automatic void predict_neighbours(input logic [IDX_W-1:0] site);
    longint unsigned total, s, idx, st, c;
    int first;
    total = lattice_sites();
    s = lat_side;
    idx = site;
    first = nbr_expect.size();
    if (lat_dims == 0 || idx >= total || idx >= MAX_SITES || total > MAX_SITES) begin
      expect_item(nb_res_t'{'0, 1'b1, 1'b0, 1'b1});
      return;
    end
    if (lat_dims == DIM_CHAIN) begin
      if (idx > 0) add_nb(idx - 1);
      if (idx + 1 < s) add_nb(idx + 1);
      if (lat_periodic && idx == 0) add_nb(s - 1);
      if (lat_periodic && idx == s - 1) add_nb(0);
    end else begin
      st = 1;
      for (int a = 0; a < lat_dims; a++) begin
        c = (idx / st) % s;
        if (c > 0) add_nb(idx - st);
        else if (lat_periodic) add_nb(idx + (s - 1) * st);
        if (c + 1 < s) add_nb(idx + st);
        else if (lat_periodic) add_nb(idx - (s - 1) * st);
        st *= s;
      end
    end
    if (nbr_expect.size() == first) expect_item(nb_res_t'{'0, 1'b1, 1'b1, 1'b0});
    else nbr_expect[nbr_expect.size() - 1].last = 1'b1;
  endfunction

  // mostly in-range sites with coordinates biased to the edges
  function automatic logic [IDX_W-1:0] pick_site();
    longint unsigned total, st, c, idx;
    total = lattice_sites();
    if (lat_dims == 0 || total == 0 || total > MAX_SITES || $urandom_range(0, 9) == 0)
      return IDX_W'($urandom_range(0, MAX_SITES - 1));
    idx = 0;
    st = 1;
    for (int a = 0; a < lat_dims; a++) begin
      case ($urandom_range(0, 2))
        0: c = 0;
        1: c = lat_side - 1;
        default: c = $urandom_range(0, lat_side - 1);
      endcase
      idx += c * st;
      st *= lat_side;
    end
    return idx[IDX_W-1:0];
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_DIMS:     lat_dims = val[DIMS_W-1:0];
      REG_SIDE:     lat_side = val[SIDE_W-1:0];
      REG_PERIODIC: lat_periodic = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (site_queue.size() != 0 || site_ch.valid || nbr_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_lattice(input int d, input int s, input bit p);
    wait_idle();
    write_reg(REG_DIMS, d);
    write_reg(REG_SIDE, s);
    write_reg(REG_PERIODIC, p);
    idle_on = ($urandom_range(0, 3) != 0);
    @(negedge clk);
  endtask

  task automatic random_lattice();
    int d, s;
    case ($urandom_range(0, 9))
      0: begin
        d = 0;
        s = $urandom_range(1, 20);
      end
      1: begin
        d = $urandom_range(1, 3);
        s = (d == DIM_CHAIN) ? $urandom_range(MAX_SITES + 1, 8191) :
            (d == DIM_SQUARE) ? $urandom_range(SQ_LIMIT + 1, 8191) :
            $urandom_range(CU_LIMIT + 1, 8191);
      end
      default: begin
        d = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
          s = (d == DIM_CHAIN) ? MAX_SITES : (d == DIM_SQUARE) ? SQ_LIMIT : CU_LIMIT;
        else
          s = (d == DIM_CHAIN) ? $urandom_range(1, 60) : $urandom_range(1, 9);
      end
    endcase
    set_lattice(d, s, $urandom_range(0, 1));
  endtask

  // site driver
  always @(posedge clk) begin
    if (rst) begin
      site_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (site_ch.valid && site_ch.ready) predict_neighbours(site_ch.site_index);
      if (!site_ch.valid || site_ch.ready) begin
        if (send_gap > 0) begin
          site_ch.valid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (site_queue.size() != 0) begin
          site_ch.valid      <= 1'b1;
          site_ch.site_index <= site_queue.pop_front();
          send_gap           <= idle_len();
        end else begin
          site_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      nb_ch.ready <= 1'b0;
      stall_left  <= 0;
      hold_done   <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      nb_ch.ready <= 1'b0;
      hold_done   <= 1'b1;
      stall_left  <= HOLD_CYCLES;
    end else if (stall_left != 0) begin
      nb_ch.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      recv_gap = idle_len();
      nb_ch.ready <= (recv_gap == 0);
      stall_left  <= (recv_gap > 0) ? recv_gap - 1 : 0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && nb_ch.valid && nb_ch.ready) begin
      if (nbr_expect.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual idx %0d last %0b none %0b oor %0b",
                 $time, nb_ch.neighbour_index, nb_ch.is_last, nb_ch.no_neighbour,
                 nb_ch.out_of_range);
        errors++;
      end else begin
        want = nbr_expect.pop_front();
        check_field("neighbour_index", want.nb, nb_ch.neighbour_index);
        check_field("is_last", want.last, nb_ch.is_last);
        check_field("no_neighbour", want.none, nb_ch.no_neighbour);
        check_field("out_of_range", want.oor, nb_ch.out_of_range);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (site_ch.valid && site_ch.ready) || (nb_ch.valid && nb_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("** lattice_neighbour_generator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    site_ch.valid      = 1'b0;
    site_ch.site_index = '0;
    nb_ch.ready        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one-site periodic chain after reset, then a site past its end
    queue_site(IDX_W'(0));
    queue_site(IDX_W'(1));

    set_lattice(DIM_CHAIN, MAX_SITES, 1'b0);
    queue_site(IDX_W'(0));
    queue_site(IDX_W'(MAX_SITES - 1));
    set_lattice(DIM_CHAIN, MAX_SITES, 1'b1);
    queue_site(IDX_W'(0));
    queue_site(IDX_W'(MAX_SITES - 1));
    set_lattice(DIM_CHAIN, 2, 1'b1);
    queue_site(IDX_W'(0));

    set_lattice(DIM_SQUARE, SQ_LIMIT, 1'b1);
    queue_site(IDX_W'(0));
    queue_site(IDX_W'(MAX_SITES - 1));
    queue_site(IDX_W'(2080));
    set_lattice(DIM_SQUARE, SQ_LIMIT, 1'b0);
    queue_site(IDX_W'(SQ_LIMIT - 1));

    set_lattice(DIM_CUBE, CU_LIMIT, 1'b1);
    queue_site(IDX_W'(0));
    queue_site(IDX_W'(MAX_SITES - 1));
    set_lattice(DIM_CUBE, CU_LIMIT, 1'b0);
    queue_site(IDX_W'(273));
    // side two: wrapped and plain neighbours coincide
    set_lattice(DIM_CUBE, 2, 1'b1);
    queue_site(IDX_W'(7));
    // single-site lattices with open edges have no neighbour
    set_lattice(DIM_SQUARE, 1, 1'b0);
    queue_site(IDX_W'(0));
    set_lattice(DIM_CHAIN, 1, 1'b0);
    queue_site(IDX_W'(0));

    // out of limits: no dimension, empty lattice, oversized lattice, site past end
    set_lattice(0, 5, 1'b1);
    queue_site(IDX_W'(0));
    set_lattice(DIM_CHAIN, 0, 1'b1);
    queue_site(IDX_W'(0));
    set_lattice(DIM_CUBE, CU_LIMIT + 1, 1'b1);
    queue_site(IDX_W'(0));
    set_lattice(DIM_SQUARE, 8191, 1'b0);
    queue_site(IDX_W'(0));
    set_lattice(DIM_CHAIN, 16, 1'b1);
    queue_site(IDX_W'(16));

    // long result stall while sites keep coming
    set_lattice(DIM_CHAIN, MAX_SITES, 1'b1);
    hold_armed <= 1'b1;
    repeat (30) queue_site(pick_site());

    repeat (6) begin
      random_lattice();
      repeat (11) queue_site(pick_site());
    end

    wait_idle();
    if (errors == 0) begin
      $display("** lattice_neighbour_generator: PASSED **");
    end else begin
      $display("** lattice_neighbour_generator: FAILED **");
    end
    $finish;
  end

endmodule
